// ===== hw/rtl/pfc_pkg.sv =====
// Shared constants and types for the pixel format converter.
package pfc_pkg;

    localparam int CH_MAX_W = 16;                  // width of one channel maximum field
    localparam int PIX_W    = 32;                  // pixel word width
    localparam int NARROW_W = 16;                  // 16-bit pixel width
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W    = PIX_W + CH_MAX_W;    // product / dividend width
    localparam int NUM_CH   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_MASK_AR = 3'd0,
        REG_SRC_MASK_GB = 3'd1,
        REG_DST_MASK_AR = 3'd2,
        REG_DST_MASK_GB = 3'd3,
        REG_SRC_LAYOUT  = 3'd4,
        REG_DST_LAYOUT  = 3'd5,
        REG_SRC_MAX     = 3'd6,
        REG_DST_MAX     = 3'd7
    } t_cfg_reg;

    localparam logic [1:0] SIZE_16 = 2'd0;
    localparam logic [1:0] SIZE_32 = 2'd1;

    typedef struct packed {
        logic [CH_MAX_W-1:0] factor;    // multiplier applied to the channel
        logic [CH_MAX_W-1:0] divisor;   // never zero
    } t_scale;

endpackage

// ===== hw/rtl/pixel_format_converter_unit.sv =====
// Pixel format converter: mask/shift channel extraction, integer rescale, repack.
//
// Usage:
//   Source pixels arrive on the slave stream (i_s_*), one 32-bit word per
//   request; converted pixels leave on the master stream (o_m_*), with
//   o_m_tuser set when the pixel was produced (both size codes supported).
//   Registers are loaded through i_cfg_we / i_cfg_idx / i_cfg_data while the
//   stream is idle; each write takes effect on the next clock.
// Pipeline: 51 register stages from the accepting edge to o_m_tvalid: one
//   extract stage, one multiply stage, 48 divider stages (one quotient bit
//   per stage over the 48-bit product) and the repack output register.
// Throughput: one pixel per clock unless stalled; holds up to 51 requests.
// Stall: when the receiver drops i_m_tready with a result waiting, the whole
//   pipeline freezes and o_s_tready falls; nothing is dropped or repeated.
// Reset: i_rst_n low on a clock edge clears all valid bits and zeroes all
//   configuration registers.
module pixel_format_converter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfc_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,   // [31:0] source_pixel
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // [31:0] dest_pixel
    output logic                            o_m_tuser    // [0] pixel_written
);
    import pfc_pkg::*;

    localparam int NSTG = DIV_W + 3;

    logic [CFG_W-1:0] r_src_mask_ar, r_src_mask_gb, r_dst_mask_ar, r_dst_mask_gb;
    logic [22:0]      r_src_layout;
    logic [21:0]      r_dst_layout;
    logic [CFG_W-1:0] r_src_max, r_dst_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_mask_ar <= '0;
            r_src_mask_gb <= '0;
            r_dst_mask_ar <= '0;
            r_dst_mask_gb <= '0;
            r_src_layout  <= '0;
            r_dst_layout  <= '0;
            r_src_max     <= '0;
            r_dst_max     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_SRC_MASK_AR: r_src_mask_ar <= i_cfg_data;
                REG_SRC_MASK_GB: r_src_mask_gb <= i_cfg_data;
                REG_DST_MASK_AR: r_dst_mask_ar <= i_cfg_data;
                REG_DST_MASK_GB: r_dst_mask_gb <= i_cfg_data;
                REG_SRC_LAYOUT:  r_src_layout  <= i_cfg_data[22:0];
                REG_DST_LAYOUT:  r_dst_layout  <= i_cfg_data[21:0];
                REG_SRC_MAX:     r_src_max     <= i_cfg_data;
                REG_DST_MAX:     r_dst_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // user must keep config static while requests are in flight (unenforced by the block); stages read it directly
    logic [1:0] ssize, dsize;
    logic       rescale, supported;
    assign ssize     = r_src_layout[21:20];
    assign dsize     = r_dst_layout[21:20];
    assign rescale   = r_src_layout[22];
    assign supported = (ssize == SIZE_16 || ssize == SIZE_32) &&
                       (dsize == SIZE_16 || dsize == SIZE_32);

    logic [PIX_W-1:0] src_mask [NUM_CH];
    logic [PIX_W-1:0] dst_mask [NUM_CH];
    assign src_mask[0] = r_src_mask_ar[63:32];
    assign src_mask[1] = r_src_mask_ar[31:0];
    assign src_mask[2] = r_src_mask_gb[63:32];
    assign src_mask[3] = r_src_mask_gb[31:0];
    assign dst_mask[0] = r_dst_mask_ar[63:32];
    assign dst_mask[1] = r_dst_mask_ar[31:0];
    assign dst_mask[2] = r_dst_mask_gb[63:32];
    assign dst_mask[3] = r_dst_mask_gb[31:0];

    logic              adv;
    logic [NSTG-1:0]   r_vld;
    logic [PIX_W-1:0]  sp;
    logic [PIX_W-1:0]  r_v [NUM_CH];
    logic [PIX_W-1:0]  quot [NUM_CH];
    t_scale            scale [NUM_CH];
    logic [PIX_W-1:0]  n_pix;
    logic [PIX_W-1:0]  r_pix;

    assign adv        = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    assign sp = (ssize == SIZE_16) ? {{(PIX_W-NARROW_W){1'b0}}, i_s_tdata[NARROW_W-1:0]}
                                   : i_s_tdata;

    genvar c;
    generate
        for (c = 0; c < NUM_CH; c++) begin : g_ch
            logic [CH_MAX_W-1:0] smax, dmax;
            assign smax = r_src_max[16*(3-c) +: CH_MAX_W];
            assign dmax = r_dst_max[16*(3-c) +: CH_MAX_W];

            // pass-through is x*1/1; zero source maximum forces x*0/1
            always_comb begin
                if (!rescale) begin
                    scale[c].factor  = CH_MAX_W'(1);
                    scale[c].divisor = CH_MAX_W'(1);
                end else if (smax == '0) begin
                    scale[c].factor  = '0;
                    scale[c].divisor = CH_MAX_W'(1);
                end else begin
                    scale[c].factor  = dmax;
                    scale[c].divisor = smax;
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_v[c] <= (sp & src_mask[c]) >> r_src_layout[5*c +: 5];
                end
            end

            pfc_scale_lane u_lane (
                .i_clk      (i_clk),
                .i_en       (adv),
                .i_value    (r_v[c]),
                .i_scale    (scale[c]),
                .o_quotient (quot[c])
            );
        end
    endgenerate

    always_comb begin
        n_pix = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            n_pix = n_pix | ((quot[k] << r_dst_layout[5*k +: 5]) & dst_mask[k]);
        end
        if (dsize == SIZE_16) begin
            n_pix = {{(PIX_W-NARROW_W){1'b0}}, n_pix[NARROW_W-1:0]};
        end
        if (!supported) begin
            n_pix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pix <= n_pix;
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = r_pix;
    assign o_m_tuser  = supported;

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("valid after reset");
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("unwritten pixel carries data");
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken during stall");
`endif

endmodule

// ===== hw/rtl/pfc_scale_lane.sv =====
// One channel lane: registered multiply, then a one-bit-per-stage restoring divider.
module pfc_scale_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pfc_pkg::PIX_W-1:0]   i_value,
    input  pfc_pkg::t_scale             i_scale,
    output logic [pfc_pkg::PIX_W-1:0]   o_quotient
);
    import pfc_pkg::*;

    logic [DIV_W-1:0]    r_prod;
    logic [CH_MAX_W-1:0] r_rem [DIV_W];
    logic [DIV_W-1:0]    r_dq  [DIV_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= DIV_W'(i_value) * DIV_W'(i_scale.factor);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_W; g++) begin : g_stage
            logic [CH_MAX_W-1:0] rem_in;
            logic [DIV_W-1:0]    dq_in;
            logic [CH_MAX_W:0]   trial;
            logic [CH_MAX_W:0]   diff;
            logic                ge;
            logic [CH_MAX_W-1:0] n_rem;
            logic [DIV_W-1:0]    n_dq;

            if (g == 0) begin : g_first
                assign rem_in = '0;
                assign dq_in  = r_prod;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign dq_in  = r_dq[g-1];
            end

            always_comb begin
                trial = {rem_in, dq_in[DIV_W-1]};
                diff  = trial - {1'b0, i_scale.divisor};
                ge    = (trial >= {1'b0, i_scale.divisor});
                n_rem = ge ? diff[CH_MAX_W-1:0] : trial[CH_MAX_W-1:0];
                n_dq  = {dq_in[DIV_W-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_dq[g]  <= n_dq;
                end
            end
        end
    endgenerate

    assign o_quotient = r_dq[DIV_W-1][PIX_W-1:0];

endmodule
